// ----- rtl/core/rudp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rudp_pkg
// Shared flag masks, phase and delivery codes, and the request and result
// records passed between the parts of the receiver.
// ----------------------------------------------------------------------------
package rudp_pkg;

    // header flag masks
    localparam logic [6:0] F_SYN   = 7'h01;
    localparam logic [6:0] F_FIN   = 7'h02;
    localparam logic [6:0] F_START = 7'h04;
    localparam logic [6:0] F_END   = 7'h08;
    localparam logic [6:0] F_ACK   = 7'h10;
    localparam logic [6:0] F_EXT   = 7'h20;
    localparam logic [6:0] F_RE    = 7'h40;

    // session phase codes
    localparam logic [2:0] PH_LISTEN  = 3'd0;
    localparam logic [2:0] PH_SYNRCVD = 3'd1;
    localparam logic [2:0] PH_NAME    = 3'd2;
    localparam logic [2:0] PH_RECV    = 3'd3;
    localparam logic [2:0] PH_CLOSING = 3'd4;
    localparam logic [2:0] PH_CLOSED  = 3'd5;

    // payload delivery codes
    localparam logic [1:0] DK_NONE = 2'd0;
    localparam logic [1:0] DK_NAME = 2'd1;
    localparam logic [1:0] DK_DATA = 2'd2;

    // classified header request
    typedef struct packed {
        logic        syn;
        logic        fin;
        logic        start;
        logic        is_end;
        logic        ack_flag;
        logic        ext;
        logic        ack_is_one;
        logic [15:0] seq;
        logic [15:0] seq_inc;
        logic [15:0] ack_inc;
        logic [10:0] len;
    } cmd_t;

    // reply decision
    typedef struct packed {
        logic        reply_valid;
        logic [6:0]  reply_flags;
        logic [15:0] reply_ack;
        logic [1:0]  deliver_kind;
        logic [10:0] deliver_len;
        logic [2:0]  phase;
    } res_t;

endpackage
`default_nettype wire

// ----- rtl/core/rudp_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rudp_fifo
// Small first-in first-out queue of requests with push/full and pop/empty
// sides; a push and a pop may complete in the same cycle.
// ----------------------------------------------------------------------------
module rudp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    // status and handshake
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    // fill count stays within the queue depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("rudp_fifo: fill count beyond depth");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/rudp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rudp_front
// Accepts received headers, decodes the flag bits and precomputes the
// incremented numbers, and queues the classified request for the back end.
// ----------------------------------------------------------------------------
module rudp_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [6:0]   pkt_flags,
    input  wire logic [15:0]  pkt_seq,
    input  wire logic [15:0]  pkt_ack,
    input  wire logic [10:0]  pkt_len,
    output logic              cmd_valid,
    output rudp_pkg::cmd_t    cmd,
    input  wire logic         cmd_pop
);

    rudp_pkg::cmd_t                  cmd_in;
    logic [$bits(rudp_pkg::cmd_t)-1:0] cmd_raw;
    logic                            cmd_empty;

    // flag decode and number increments
    always_comb
    begin
        cmd_in.syn        = (pkt_flags & rudp_pkg::F_SYN) != '0;
        cmd_in.fin        = (pkt_flags & rudp_pkg::F_FIN) != '0;
        cmd_in.start      = (pkt_flags & rudp_pkg::F_START) != '0;
        cmd_in.is_end     = (pkt_flags & rudp_pkg::F_END) != '0;
        cmd_in.ack_flag   = (pkt_flags & rudp_pkg::F_ACK) != '0;
        cmd_in.ext        = (pkt_flags & rudp_pkg::F_EXT) != '0;
        cmd_in.ack_is_one = (pkt_ack == 16'd1);
        cmd_in.seq        = pkt_seq;
        cmd_in.seq_inc    = pkt_seq + 16'd1;
        cmd_in.ack_inc    = pkt_ack + 16'd1;
        cmd_in.len        = pkt_len;
    end

    // request queue toward the back end
    rudp_fifo #(
        .WIDTH ($bits(rudp_pkg::cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_raw),
        .empty (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;
    assign cmd       = rudp_pkg::cmd_t'(cmd_raw);

endmodule
`default_nettype wire

// ----- rtl/core/rudp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rudp_back
// Session engine: takes one classified request per cycle while a result slot is
// free, walks the phase machine, tracks the receive window and produces the reply decision.
// ----------------------------------------------------------------------------
module rudp_back #(
    parameter int WINDOW = 1
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    input  wire rudp_pkg::cmd_t  cmd,
    output logic                 cmd_pop,
    input  wire logic            res_full,
    output logic                 res_push,
    output rudp_pkg::res_t       res
);

    localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    typedef enum logic [2:0] {
        ST_LISTEN  = rudp_pkg::PH_LISTEN,
        ST_SYNRCVD = rudp_pkg::PH_SYNRCVD,
        ST_NAME    = rudp_pkg::PH_NAME,
        ST_RECV    = rudp_pkg::PH_RECV,
        ST_CLOSING = rudp_pkg::PH_CLOSING,
        ST_CLOSED  = rudp_pkg::PH_CLOSED
    } phase_t;

    phase_t            phase_reg,    phase_next;
    logic [15:0]       expected_reg, expected_next;
    logic [16:0]       wb_reg,       wb_next;
    logic [SW-1:0]     slot_reg,     slot_next;
    logic [15:0]       prev_ack_reg, prev_ack_next;
    logic [WINDOW-1:0] marks_reg,    marks_next;

    logic              fire;
    logic [16:0]       seq_w;
    logic              in_window;
    logic              re_hit;
    logic [WINDOW-1:0] marks_set;
    logic [WINDOW-1:0] marks_one;
    logic [16:0]       wb_one;
    logic [SW-1:0]     slot_one;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        slot_inc = (s == SW'(WINDOW - 1)) ? '0 : s + SW'(1);
    endfunction

    // handshake: one request moves when a result slot is free
    assign fire     = cmd_valid && !res_full;
    assign cmd_pop  = fire;
    assign res_push = fire;

    // window compares
    assign seq_w     = {1'b0, cmd.seq};
    assign in_window = (seq_w >= wb_reg) && (seq_w < wb_reg + 17'(WINDOW));
    assign re_hit    = (seq_w == ({1'b0, expected_reg} + 17'd1));

    // window slide: the slot of the accepted seq, then at most one leftover mark
    always_comb
    begin
        marks_set = marks_reg;
        marks_set[slot_reg] = 1'b1;
        marks_one = marks_set;
        marks_one[slot_reg] = 1'b0;
        wb_one   = wb_reg + 17'd1;
        slot_one = slot_inc(slot_reg);
    end

    // phase machine and reply decision
    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        wb_next       = wb_reg;
        slot_next     = slot_reg;
        prev_ack_next = prev_ack_reg;
        marks_next    = marks_reg;
        res           = '0;

        unique case (phase_reg)
            ST_LISTEN:
            begin
                if (cmd.syn)
                begin
                    res.reply_valid = 1'b1;
                    res.reply_flags = rudp_pkg::F_SYN | rudp_pkg::F_ACK | rudp_pkg::F_EXT;
                    res.reply_ack   = cmd.seq_inc;
                    phase_next      = ST_SYNRCVD;
                end
            end
            ST_SYNRCVD:
            begin
                if (cmd.ext && cmd.ack_flag && cmd.ack_is_one)
                begin
                    phase_next = ST_NAME;
                end
            end
            ST_NAME:
            begin
                if (cmd.fin)
                begin
                    res.reply_valid = 1'b1;
                    res.reply_flags = rudp_pkg::F_FIN | rudp_pkg::F_EXT;
                    phase_next      = ST_CLOSING;
                end
                else if (cmd.start)
                begin
                    res.reply_valid  = 1'b1;
                    res.reply_flags  = rudp_pkg::F_ACK | rudp_pkg::F_EXT;
                    res.reply_ack    = cmd.seq;
                    res.deliver_kind = rudp_pkg::DK_NAME;
                    res.deliver_len  = cmd.len;
                    expected_next    = '0;
                    wb_next          = '0;
                    slot_next        = '0;
                    prev_ack_next    = '0;
                    phase_next       = ST_RECV;
                end
            end
            ST_RECV:
            begin
                if (cmd.ext)
                begin
                    if (cmd.is_end)
                    begin
                        res.reply_valid = 1'b1;
                        res.reply_flags = rudp_pkg::F_END | rudp_pkg::F_ACK | rudp_pkg::F_EXT;
                        res.reply_ack   = cmd.ack_inc;
                        wb_next         = '0;
                        slot_next       = '0;
                        phase_next      = ST_NAME;
                    end
                    else if (in_window)
                    begin
                        // only the in-order seq is taken, and it sits at the window base
                        if (cmd.seq == expected_reg)
                        begin
                            res.reply_valid  = 1'b1;
                            res.reply_flags  = rudp_pkg::F_ACK | rudp_pkg::F_EXT;
                            res.reply_ack    = cmd.seq_inc;
                            res.deliver_kind = rudp_pkg::DK_DATA;
                            res.deliver_len  = cmd.len;
                            prev_ack_next    = cmd.seq_inc;
                            expected_next    = expected_reg + 16'd1;
                            if (!wb_one[16] && marks_one[slot_one])
                            begin
                                marks_next = marks_one;
                                marks_next[slot_one] = 1'b0;
                                wb_next    = wb_one + 17'd1;
                                slot_next  = slot_inc(slot_one);
                            end
                            else
                            begin
                                marks_next = marks_one;
                                wb_next    = wb_one;
                                slot_next  = slot_one;
                            end
                        end
                    end
                    else if (re_hit)
                    begin
                        res.reply_valid = 1'b1;
                        res.reply_flags = rudp_pkg::F_ACK | rudp_pkg::F_RE | rudp_pkg::F_EXT;
                        res.reply_ack   = prev_ack_reg - 16'd1;
                    end
                end
            end
            ST_CLOSING:
            begin
                if (cmd.ack_flag)
                begin
                    phase_next = ST_CLOSED;
                end
            end
            ST_CLOSED:
            begin
                phase_next = ST_CLOSED;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        res.phase = phase_next;
    end

    // session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ST_LISTEN;
            expected_reg <= '0;
            wb_reg       <= '0;
            slot_reg     <= '0;
            prev_ack_reg <= '0;
            marks_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            wb_reg       <= wb_next;
            slot_reg     <= slot_next;
            prev_ack_reg <= prev_ack_next;
            marks_reg    <= marks_next;
        end
    end

`ifndef ASSERT_OFF
    // a closed session never reopens
    a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ST_CLOSED |=> phase_reg == ST_CLOSED)
        else $error("rudp_back: left the closed phase");
`endif

`ifndef ASSERT_OFF
    // window base never runs past the end of the sequence space
    a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wb_reg <= 17'h10000)
        else $error("rudp_back: window base beyond sequence space");
`endif

`ifndef ASSERT_OFF
    // delivered data is acked with the next seq and keeps the session receiving
    a_data_ack: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res.deliver_kind == rudp_pkg::DK_DATA
        |-> res.reply_ack == cmd.seq_inc && res.phase == rudp_pkg::PH_RECV
            && res.reply_valid)
        else $error("rudp_back: data delivery without matching ack");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/reliable_udp_receiver_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// reliable_udp_receiver_fsm
// Receiver side of a stop-and-wait transfer: one reply decision per header.
// ----------------------------------------------------------------------------
// Push one received header (flags, seq, ack, len) per cycle while full is low;
// for each header exactly one decision appears on the result side, in order:
// whether to send a reply and with which flags and ack, what payload to hand
// on, and the session phase after that header. Headers are taken back to back
// at one per clock while the request queue has room; a decision passes the
// request queue and the session engine, which updates phase, expected seq
// and window base for each header, and can then be popped from the result
// queue. Both sides are two-entry queues, so either side may stall without
// losing a request. After reset the session listens for a SYN.
module reliable_udp_receiver_fsm #(
    parameter int WINDOW = 1
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [6:0]  pkt_flags,
    input  wire logic [15:0] pkt_seq,
    input  wire logic [15:0] pkt_ack,
    input  wire logic [10:0] pkt_len,
    output logic             empty,
    input  wire logic        pop,
    output logic             reply_valid,
    output logic [6:0]       reply_flags,
    output logic [15:0]      reply_ack,
    output logic [1:0]       deliver_kind,
    output logic [10:0]      deliver_len,
    output logic [2:0]       phase
);

    rudp_pkg::cmd_t                    cmd;
    logic                              cmd_valid;
    logic                              cmd_pop;
    rudp_pkg::res_t                    res;
    logic                              res_push;
    logic                              res_full;
    logic [$bits(rudp_pkg::res_t)-1:0] res_raw;
    rudp_pkg::res_t                    res_out;

    // header intake and classification
    rudp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pkt_flags (pkt_flags),
        .pkt_seq   (pkt_seq),
        .pkt_ack   (pkt_ack),
        .pkt_len   (pkt_len),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // session engine
    rudp_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // result queue
    rudp_fifo #(
        .WIDTH ($bits(rudp_pkg::res_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_raw),
        .empty (empty)
    );

    // result fields
    assign res_out      = rudp_pkg::res_t'(res_raw);
    assign reply_valid  = res_out.reply_valid;
    assign reply_flags  = res_out.reply_flags;
    assign reply_ack    = res_out.reply_ack;
    assign deliver_kind = res_out.deliver_kind;
    assign deliver_len  = res_out.deliver_len;
    assign phase        = res_out.phase;

endmodule
`default_nettype wire
